// File: design/crsf_pkg.sv
// ----------------------------------------------------------------------------
// crsf_pkg
// Shared types, constants and the crc step for the rc channels frame encoder.
// ----------------------------------------------------------------------------
`default_nettype none

package crsf_pkg;

  localparam int unsigned NumLanes    = 8;
  localparam int unsigned NumChannels = 16;
  localparam int unsigned ChanW       = 11;
  localparam int unsigned UsW         = 16;
  localparam int unsigned PayloadW    = NumChannels * ChanW;  // 176 bits, 22 bytes

  typedef logic [ChanW-1:0] chan_t;
  typedef logic [4:0]       byte_idx_t;
  typedef logic [7:0]       byte_t;

  // frame byte positions
  localparam byte_idx_t IdxAddr       = 5'd0;
  localparam byte_idx_t IdxLen        = 5'd1;
  localparam byte_idx_t IdxType       = 5'd2;
  localparam byte_idx_t IdxPayFirst   = 5'd3;
  localparam byte_idx_t IdxPayLast    = 5'd24;
  localparam byte_idx_t IdxCrc        = 5'd25;

  localparam byte_t FrameLen   = 8'd24;
  localparam byte_t FrameType  = 8'h16;
  localparam byte_t CrcPoly    = 8'hD5;
  localparam byte_t DestReset  = 8'hC8;

  localparam logic [UsW-1:0] UsMin = 16'd1000;
  localparam logic [UsW-1:0] UsMid = 16'd1500;
  localparam logic [UsW-1:0] UsMax = 16'd2000;

  localparam chan_t CrsfMin = 11'd172;
  localparam chan_t CrsfMid = 11'd992;
  localparam chan_t CrsfMax = 11'd1811;

  // floor(m * 819 / 500) for m <= 500 as (m * ScaleMult) >> ScaleShift
  localparam int unsigned ScaleShift = 20;
  localparam logic [20:0] ScaleMult  = 21'd1717568;

  function automatic byte_t crc8_step(input byte_t crc, input byte_t data);
    byte_t c;
    c = crc ^ data;
    for (int b = 0; b < 8; b++) begin
      if (c[7]) begin
        c = {c[6:0], 1'b0} ^ CrcPoly;
      end else begin
        c = {c[6:0], 1'b0};
      end
    end
    return c;
  endfunction

endpackage

`default_nettype wire

// File: design/crsf_rc_frame_encoder.sv
// ----------------------------------------------------------------------------
// crsf_rc_frame_encoder
// Turns eight rc pulse widths into a 26-byte crsf rc channels frame.
// ----------------------------------------------------------------------------
//  channel   dir  payload                                   handshake
//  s_axis    in   8 x 16-bit widths, roll in bits 15:0      tvalid/tready
//  m_axis    out  frame byte, tlast on the crc byte         tvalid/tready
//  cfg       in   destination address, 8 bits               we, no wait
//
//  a frame is 26 bytes, one byte per cycle on the output port while the sink is ready
//  eight lanes scale the channels combinationally and register them; the next word waits in the
//  lane registers and is taken while the current frame is still sent
//  reset puts the address back to 0xC8 and empties both stages
//  output stalls only hold the frame; unless the framer takes them, input is stalled once lanes are full
// ----------------------------------------------------------------------------
`default_nettype none

module crsf_rc_frame_encoder (
  input  wire logic         clk_i,
  input  wire logic         rst_ni,
  input  wire logic         s_axis_tvalid_i,
  output logic              s_axis_tready_o,
  // roll, pitch, throttle, yaw, aux1, aux2, aux3, aux4 (16 bits each, lsb up)
  input  wire logic [127:0] s_axis_tdata_i,
  output logic              m_axis_tvalid_o,
  input  wire logic         m_axis_tready_i,
  // frame_byte
  output logic [7:0]        m_axis_tdata_o,
  output logic              m_axis_tlast_o,
  input  wire logic         cfg_we_i,
  input  wire logic [7:0]   cfg_wdata_i
);
  import crsf_pkg::*;

  logic [7:0]          dest_q;
  logic                lane_valid_d, lane_valid_q;
  logic                load_ready, in_fire;
  chan_t               chans [NumLanes];
  logic [PayloadW-1:0] payload;

  assign s_axis_tready_o = !lane_valid_q || load_ready;
  assign in_fire         = s_axis_tvalid_i && s_axis_tready_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dest_q <= DestReset;
    end else if (cfg_we_i) begin
      dest_q <= cfg_wdata_i;
    end
  end

  for (genvar g = 0; g < NumLanes; g++) begin : g_lane
    crsf_lane u_lane (
      .clk_i  (clk_i),
      .en_i   (in_fire),
      .us_i   (s_axis_tdata_i[g*UsW +: UsW]),
      .chan_o (chans[g])
    );
    assign payload[g*ChanW +: ChanW] = chans[g];
  end

  // channels 9 to 16 sit at center
  for (genvar g = NumLanes; g < NumChannels; g++) begin : g_fixed
    assign payload[g*ChanW +: ChanW] = CrsfMid;
  end

  always_comb begin
    lane_valid_d = lane_valid_q;
    if (in_fire) begin
      lane_valid_d = 1'b1;
    end else if (load_ready) begin
      lane_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      lane_valid_q <= 1'b0;
    end else begin
      lane_valid_q <= lane_valid_d;
    end
  end

  crsf_framer u_framer (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .load_valid_i    (lane_valid_q),
    .load_ready_o    (load_ready),
    .payload_i       (payload),
    .dest_i          (dest_q),
    .m_axis_tvalid_o (m_axis_tvalid_o),
    .m_axis_tready_i (m_axis_tready_i),
    .m_axis_tdata_o  (m_axis_tdata_o),
    .m_axis_tlast_o  (m_axis_tlast_o)
  );

endmodule

`default_nettype wire

// File: design/crsf_lane.sv
// ----------------------------------------------------------------------------
// crsf_lane
// One channel: clamp a pulse width, scale it to a crsf value, register it.
// ----------------------------------------------------------------------------
`default_nettype none

module crsf_lane (
  input  wire logic                    clk_i,
  input  wire logic                    en_i,
  input  wire logic [crsf_pkg::UsW-1:0] us_i,
  output crsf_pkg::chan_t              chan_o
);
  import crsf_pkg::*;

  logic [UsW-1:0] lim;
  logic           neg;
  logic [8:0]     mag;
  logic [29:0]    prod;
  logic [9:0]     quot;
  logic [11:0]    val;
  chan_t          chan_d, chan_q;

  always_comb begin
    if (us_i < UsMin) begin
      lim = UsMin;
    end else if (us_i > UsMax) begin
      lim = UsMax;
    end else begin
      lim = us_i;
    end
    neg = (lim < UsMid);
    if (neg) begin
      mag = 9'(UsMid - lim);
    end else begin
      mag = 9'(lim - UsMid);
    end
    prod = 30'(mag) * 30'(ScaleMult);
    quot = prod[ScaleShift+9:ScaleShift];
    if (neg) begin
      val = 12'(CrsfMid) - 12'(quot);
    end else begin
      val = 12'(CrsfMid) + 12'(quot);
    end
    // never reached by the scaled range, kept for safety
    if (val < 12'(CrsfMin)) begin
      chan_d = CrsfMin;
    end else if (val > 12'(CrsfMax)) begin
      chan_d = CrsfMax;
    end else begin
      chan_d = val[ChanW-1:0];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      chan_q <= chan_d;
    end
  end

  assign chan_o = chan_q;

endmodule

`default_nettype wire

// File: design/crsf_framer.sv
// ----------------------------------------------------------------------------
// crsf_framer
// Merges the lane results into one frame and sends it a byte per cycle while the sink is ready.
// ----------------------------------------------------------------------------
`default_nettype none

module crsf_framer (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  input  wire logic                         load_valid_i,
  output logic                              load_ready_o,
  input  wire logic [crsf_pkg::PayloadW-1:0] payload_i,
  input  wire logic [7:0]                   dest_i,
  output logic                              m_axis_tvalid_o,
  input  wire logic                         m_axis_tready_i,
  output logic [7:0]                        m_axis_tdata_o,
  output logic                              m_axis_tlast_o
);
  import crsf_pkg::*;

  logic                busy_d, busy_q;
  byte_idx_t           idx_d, idx_q;
  logic [PayloadW-1:0] pay_d, pay_q;
  byte_t               crc_d, crc_q;
  byte_t               cur_byte;
  logic                fire, at_end, load;

  always_comb begin
    case (idx_q)
      IdxAddr: cur_byte = dest_i;
      IdxLen:  cur_byte = FrameLen;
      IdxType: cur_byte = FrameType;
      IdxCrc:  cur_byte = crc_q;
      default: cur_byte = pay_q[7:0];
    endcase
  end

  assign fire         = busy_q && m_axis_tready_i;
  assign at_end       = (idx_q == IdxCrc);
  assign load_ready_o = !busy_q || (fire && at_end);
  assign load         = load_valid_i && load_ready_o;

  always_comb begin
    busy_d = busy_q;
    idx_d  = idx_q;
    pay_d  = pay_q;
    crc_d  = crc_q;
    if (load) begin
      busy_d = 1'b1;
      idx_d  = IdxAddr;
      pay_d  = payload_i;
      crc_d  = '0;
    end else if (fire) begin
      if (at_end) begin
        busy_d = 1'b0;
      end else begin
        idx_d = idx_q + 5'd1;
        if (idx_q >= IdxType) begin
          crc_d = crc8_step(crc_q, cur_byte);
        end
        if (idx_q >= IdxPayFirst && idx_q <= IdxPayLast) begin
          pay_d = {8'd0, pay_q[PayloadW-1:8]};
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      idx_q  <= IdxAddr;
    end else begin
      busy_q <= busy_d;
      idx_q  <= idx_d;
    end
  end

  always_ff @(posedge clk_i) begin
    pay_q <= pay_d;
    crc_q <= crc_d;
  end

  assign m_axis_tvalid_o = busy_q;
  assign m_axis_tdata_o  = cur_byte;
  assign m_axis_tlast_o  = at_end;

endmodule

`default_nettype wire
